FILE: src/rtcm2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM 2 word deframer package
// Types, constants and the GPS word parity check shared by the deframer.
// ----------------------------------------------------------------------------
package rtcm2_pkg;

  localparam int unsigned DataW   = 24;
  localparam int unsigned WinW    = 32;
  localparam int unsigned SymW    = 6;
  localparam int unsigned PosW    = 7;
  localparam int unsigned LenW    = 6;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ParW    = 6;

  localparam logic [7:0]      PREAMBLE     = 8'h66;
  localparam logic [1:0]      SYM_TAG      = 2'b01;
  localparam logic [CntW-1:0] SYMS_PER_WORD = 3'd5;
  localparam logic [WinW-1:0] WIN_RESET    = 32'hC000_0000;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_HEAD2 = 2'd1,
    MODE_BODY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_HEAD1 = 2'd0,
    KIND_HEAD2 = 2'd1,
    KIND_BODY  = 2'd2,
    KIND_PERR  = 2'd3
  } kind_e;

  localparam logic [DataW-1:0] PAR_MASK [ParW] = '{
    24'hEC7CD2, 24'h763E69, 24'hBB1F34, 24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27
  };
  localparam logic [ParW-1:0] PAR_USES_D29 = 6'b101001;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             ok;
  } word_chk_t;

  // Corrects the data bits for D30* and checks the six parity bits.
  function automatic word_chk_t word_check(input logic [WinW-1:0] win);
    word_chk_t        res;
    logic [DataW-1:0] d;
    logic [ParW-1:0]  calc;
    d = win[29:6] ^ {DataW{win[30]}};
    for (int i = 0; i < ParW; i++) begin
      calc[ParW-1-i] = ^(d & PAR_MASK[i]) ^ (PAR_USES_D29[ParW-1-i] ? win[31] : win[30]);
    end
    res.data = d;
    res.ok   = (calc == win[5:0]);
    return res;
  endfunction

endpackage

FILE: src/rtcm2_word_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM 2 word deframer core
// Frame sync, GPS parity check and header decoding of RTCM 2 serial bytes.
// ----------------------------------------------------------------------------
// The core takes one serial byte per cycle unless stalled, and gives at
// most one word result per byte. A byte is captured in an input register,
// and the window shift, the preamble test and the six parity trees run
// combinationally into the result register. A new byte can be taken every
// cycle as long as results are transferred; while a result is held off,
// the input register takes one more byte and then the input stalls. Bytes
// whose top two bits are not 01 are dropped. Writing the length format
// takes effect on the next transfer and is meant to be done while the
// core is idle.
module rtcm2_word_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  raw_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] word_data_o,
  output logic [1:0]  word_kind_o,
  output logic [6:0]  word_number_o,
  output logic        last_word_o,
  output logic [5:0]  msg_type_o,
  output logic [9:0]  station_id_o,
  output logic [12:0] modified_zcount_o,
  output logic [2:0]  sequence_number_o,
  output logic [5:0]  frame_length_o,
  output logic [2:0]  station_health_o
);

  import rtcm2_pkg::*;

  logic             len_fmt_q;
  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             s2_free, fire, accept;

  mode_e            mode_q, mode_d;
  logic [WinW-1:0]  win_q, win_d;
  logic [CntW-1:0]  sym_cnt_q, sym_cnt_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [5:0]       type_q, type_d;
  logic [9:0]       station_q, station_d;
  logic [DataW-1:0] head2_q, head2_d;

  logic             emit;
  kind_e            kind;
  logic             last;
  logic [DataW-1:0] emit_data;
  logic [SymW-1:0]  sym;
  logic [WinW-1:0]  win_shift;
  word_chk_t        chk;
  logic [LenW-1:0]  len_new;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] data_q;
  kind_e            kind_q;
  logic [PosW-1:0]  num_q;
  logic             last_q;
  logic [5:0]       otype_q;
  logic [9:0]       ostation_q;
  logic [12:0]      zcount_q;
  logic [2:0]       seq_q;
  logic [5:0]       flen_q, flen_d;
  logic [2:0]       health_q, health_d;

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && s2_free;
  assign in_stall_o = in_valid_q && !s2_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_comb begin
    for (int i = 0; i < SymW; i++) begin
      sym[SymW-1-i] = in_byte_q[i];
    end
    win_shift = {win_q[WinW-SymW-1:0], sym};
    chk       = word_check(win_shift);
    len_new   = len_fmt_q ? chk.data[7:2] : {1'b0, chk.data[7:3]};
  end

  always_comb begin
    mode_d    = mode_q;
    win_d     = win_q;
    sym_cnt_d = sym_cnt_q;
    left_d    = left_q;
    pos_d     = pos_q;
    type_d    = type_q;
    station_d = station_q;
    head2_d   = head2_q;
    emit      = 1'b0;
    kind      = KIND_HEAD1;
    last      = 1'b0;
    emit_data = chk.data;
    if (fire && in_byte_q[7:6] == SYM_TAG) begin
      win_d = win_shift;
      unique case (mode_q)
        MODE_HEAD2, MODE_BODY: begin
          sym_cnt_d = sym_cnt_q + 3'd1;
          if (sym_cnt_d == SYMS_PER_WORD) begin
            sym_cnt_d = '0;
            pos_d     = pos_q + 7'd1;
            emit      = 1'b1;
            if (!chk.ok) begin
              mode_d = MODE_HUNT;
              left_d = '0;
              kind   = KIND_PERR;
              last   = 1'b1;
            end else if (mode_q == MODE_HEAD2) begin
              head2_d = chk.data;
              left_d  = len_new;
              kind    = KIND_HEAD2;
              if (len_new == '0) begin
                mode_d = MODE_HUNT;
                last   = 1'b1;
              end else begin
                mode_d = MODE_BODY;
              end
            end else begin
              left_d = left_q - 6'd1;
              kind   = KIND_BODY;
              if (left_d == '0) begin
                mode_d = MODE_HUNT;
                last   = 1'b1;
              end
            end
          end
        end
        default: begin
          mode_d = MODE_HUNT;
          if (chk.ok && chk.data[23:16] == PREAMBLE) begin
            type_d    = chk.data[15:10];
            station_d = chk.data[9:0];
            head2_d   = '0;
            pos_d     = '0;
            sym_cnt_d = '0;
            mode_d    = MODE_HEAD2;
            emit      = 1'b1;
            kind      = KIND_HEAD1;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (len_fmt_q) begin
      flen_d   = head2_d[7:2];
      health_d = {1'b0, head2_d[1:0]};
    end else begin
      flen_d   = {1'b0, head2_d[7:3]};
      health_d = head2_d[2:0];
    end
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_fmt_q   <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_HUNT;
      win_q       <= WIN_RESET;
      sym_cnt_q   <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      type_q      <= '0;
      station_q   <= '0;
      head2_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        len_fmt_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      win_q       <= win_d;
      sym_cnt_q   <= sym_cnt_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      type_q      <= type_d;
      station_q   <= station_d;
      head2_q     <= head2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= raw_byte_i;
    end
    if (fire && emit) begin
      data_q     <= emit_data;
      kind_q     <= kind;
      num_q      <= pos_d;
      last_q     <= last;
      otype_q    <= type_d;
      ostation_q <= station_d;
      zcount_q   <= head2_d[23:11];
      seq_q      <= head2_d[10:8];
      flen_q     <= flen_d;
      health_q   <= health_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign word_data_o       = data_q;
  assign word_kind_o       = kind_q;
  assign word_number_o     = num_q;
  assign last_word_o       = last_q;
  assign msg_type_o        = otype_q;
  assign station_id_o      = ostation_q;
  assign modified_zcount_o = zcount_q;
  assign sequence_number_o = seq_q;
  assign frame_length_o    = flen_q;
  assign station_health_o  = health_q;

`ifndef SYNTH
  a_perr_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_kind_o == KIND_PERR |-> last_word_o)
    else $error("Parity error result without last word.");

  a_head1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_kind_o == KIND_HEAD1
      |-> word_number_o == '0 && word_data_o[23:16] == PREAMBLE && !last_word_o)
    else $error("First header result is malformed.");

  a_sym_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_cnt_q < SYMS_PER_WORD)
    else $error("Symbol count out of range.");

  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("Input stalled without a waiting result.");
`endif

endmodule
